// File: sv/hnn_pkg.sv
// shared types and constants for the hamming nearest neighbor selector
package hnn_pkg;

  localparam int MaxHaps   = 64;
  localparam int CountBits = 16;
  localparam int HapBits   = $clog2(MaxHaps);
  localparam int NumBits   = $clog2(MaxHaps + 1);
  localparam int MaxResults = 62;

  localparam logic [0:0] CfgHapCount      = 1'b0;
  localparam logic [0:0] CfgNeighborCount = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] alleles;
    logic [5:0]  query_hap;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] neighbor_index;
    logic       last;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input item
    logic clr_step;    // row sweep of clearing pass
    logic site_step;   // row sweep of site update
    logic scan_start;  // begin a minimum scan
    logic scan_step;   // one candidate of a minimum scan
    logic pick;        // mark best as chosen
    logic emit_start;
    logic emit_step;
  } hnn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_done;
    logic site_done;
    logic scan_done;
    logic found;
    logic picks_done;
    logic emit_done;
    logic query_ok;
  } hnn_sts_t;

endpackage

// File: sv/hamming_nearest_neighbor_select.sv
// top level of the hamming nearest neighbor selector
//
// channel | handshake            | payload
// input   | start_i / busy_o     | in_i (kind, alleles, query_hap)
// config  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// result  | result_valid_o strobe | result_o (neighbor_index, last)
//
// site beat: one count row read per cycle, each written back updated in the following cycle
// query beat: a check state, then per pick a full minimum scan plus a pick state,
//   then an emit sweep; the last result can show in the same cycle that busy drops
// reset: clearing pass over every row of the count memory, busy meanwhile
// the receiver cannot stall, results go out as a one cycle strobe
module hamming_nearest_neighbor_select (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  hnn_pkg::in_beat_t  in_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  output logic               result_valid_o,
  output hnn_pkg::out_beat_t result_o
);
  import hnn_pkg::*;

  logic [6:0] hap_count_q;
  logic [5:0] neighbor_count_q;
  hnn_cmd_t cmd;
  hnn_sts_t sts;

  // config always accepted
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hap_count_q <= 7'd64; neighbor_count_q <= 6'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHapCount:      hap_count_q <= cfg_data_i;
        CfgNeighborCount: neighbor_count_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  hnn_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .kind_i(in_i.kind),
    .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  hnn_dp u_dp (
    .clk_i, .rst_ni, .in_i, .hap_count_i(hap_count_q),
    .neighbor_count_i(neighbor_count_q), .cmd_i(cmd), .sts_o(sts),
    .valid_o(result_valid_o), .out_o(result_o)
  );
endmodule

// File: sv/hnn_ctrl.sv
// controller state machine of the nearest neighbor selector
module hnn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             kind_i,
  input  hnn_pkg::hnn_sts_t sts_i,
  output hnn_pkg::hnn_cmd_t cmd_o,
  output logic             busy_o
);
  import hnn_pkg::*;

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StSite  = 7'b0000100,
    StQchk  = 7'b0001000,
    StScan  = 7'b0010000,
    StPick  = 7'b0100000,
    StEmit  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StClear;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.row_done) state_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = kind_i ? StQchk : StSite;
        end
      end
      StSite: begin
        cmd_o.site_step = 1'b1;
        if (sts_i.site_done) state_d = StIdle;
      end
      StQchk: begin
        if (!sts_i.query_ok) state_d = StIdle;
        else begin
          cmd_o.scan_start = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = StPick;
      end
      StPick: begin
        if (sts_i.found) cmd_o.pick = 1'b1;
        if (!sts_i.found || sts_i.picks_done) begin
          cmd_o.emit_start = 1'b1;
          state_d = StEmit;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = StScan;
        end
      end
      StEmit: begin
        cmd_o.emit_step = 1'b1;
        if (sts_i.emit_done) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
endmodule

// File: sv/hnn_dp.sv
// datapath: count memory, site row sweep, minimum scan and emitter
module hnn_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hnn_pkg::in_beat_t   in_i,
  input  logic [6:0]          hap_count_i,
  input  logic [5:0]          neighbor_count_i,
  input  hnn_pkg::hnn_cmd_t   cmd_i,
  output hnn_pkg::hnn_sts_t   sts_o,
  output logic                valid_o,
  output hnn_pkg::out_beat_t  out_o
);
  import hnn_pkg::*;

  localparam logic [CountBits-1:0] CountMax = '1;

  // one row per haplotype, all lanes wide
  logic [MaxHaps-1:0][CountBits-1:0] mem_q [MaxHaps];

  logic [63:0]        alleles_q;
  logic [HapBits-1:0] query_q;
  logic [NumBits-1:0] n_q;
  logic [5:0]         want_q;
  logic [HapBits:0]   row_q;      // row counter / scan counter / emit counter
  logic [HapBits-1:0] rd_q;       // index of row data in flight
  logic               rd_v_q;
  logic [MaxHaps-1:0][CountBits-1:0] rdata_q;
  logic [MaxHaps-1:0][CountBits-1:0] qrow_q;
  logic [MaxHaps-1:0] chosen_q;
  logic               found_q;
  logic [HapBits-1:0] best_q;
  logic [CountBits-1:0] bestc_q;
  logic [6:0]         picked_q;
  logic [5:0]         emitted_q;
  logic [5:0]         total_q;

  logic [NumBits-1:0] n_use;
  assign n_use = (hap_count_i > 7'(MaxHaps)) ? NumBits'(MaxHaps) : NumBits'(hap_count_i);

  logic last_row;
  assign last_row = (row_q == (HapBits+1)'(MaxHaps - 1));

  logic [HapBits-1:0] ri;
  assign ri = row_q[HapBits-1:0];

  // site update of the row read last cycle: rd_q selects i, lanes are j
  logic [MaxHaps-1:0][CountBits-1:0] site_row;
  always_comb begin
    for (int j = 0; j < MaxHaps; j++) begin
      site_row[j] = rdata_q[j];
      if ((NumBits'(rd_q) < n_q) && (NumBits'(j) < n_q) && (NumBits'(j) != NumBits'(rd_q))
          && (alleles_q[rd_q] != alleles_q[j]) && (rdata_q[j] != CountMax))
        site_row[j] = rdata_q[j] + 1'b1;
    end
  end

  // read a row, write it back updated in the following cycle; also clears rows and loads the query row
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) mem_q[ri] <= '0;
    else if (rd_v_q) mem_q[rd_q] <= site_row;
    if (cmd_i.site_step && !row_q[HapBits]) rdata_q <= mem_q[ri];
    if (cmd_i.load) qrow_q <= mem_q[in_i.query_hap];
  end

  // scan candidate
  logic [HapBits-1:0] sj;
  assign sj = row_q[HapBits-1:0];
  logic cand;
  assign cand = (NumBits'(sj) < n_q) && (sj[HapBits-1:1] != query_q[HapBits-1:1])
                && !chosen_q[sj];

  // emitter: scan ascending over chosen
  logic [HapBits-1:0] ej;
  assign ej = row_q[HapBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; rd_q <= '0; rd_v_q <= 1'b0;
      alleles_q <= '0; query_q <= '0; n_q <= '0; want_q <= '0;
      chosen_q <= '0; found_q <= 1'b0; best_q <= '0; bestc_q <= '0;
      picked_q <= '0; emitted_q <= '0; total_q <= '0;
      valid_o <= 1'b0; out_o <= '0;
    end else begin
      valid_o <= 1'b0;
      rd_v_q  <= 1'b0;
      if (cmd_i.load) begin
        alleles_q <= in_i.alleles; query_q <= in_i.query_hap;
        n_q <= n_use; want_q <= neighbor_count_i;
        row_q <= '0; chosen_q <= '0; picked_q <= '0;
      end
      if (cmd_i.clr_step)
        row_q <= last_row ? '0 : row_q + 1'b1;
      if (cmd_i.site_step && !row_q[HapBits]) begin
        row_q  <= row_q + 1'b1;
        rd_q   <= ri;
        rd_v_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        row_q <= '0; found_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        row_q <= row_q + 1'b1;
        if (cand && (!found_q || qrow_q[sj] < bestc_q)) begin
          found_q <= 1'b1; best_q <= sj; bestc_q <= qrow_q[sj];
        end
      end
      if (cmd_i.pick) begin
        chosen_q[best_q] <= 1'b1;
        picked_q <= picked_q + 1'b1;
      end
      if (cmd_i.emit_start) begin
        row_q <= '0; emitted_q <= '0;
        total_q <= (7'(picked_q) + 7'(cmd_i.pick) > 7'(MaxResults)) ? 6'(MaxResults)
                   : 6'(picked_q + 7'(cmd_i.pick));
      end
      if (cmd_i.emit_step) begin
        row_q <= row_q + 1'b1;
        if (chosen_q[ej] && emitted_q < total_q) begin
          valid_o <= 1'b1;
          out_o.neighbor_index <= 6'(ej);
          out_o.last <= (emitted_q + 1'b1 == total_q);
          emitted_q <= emitted_q + 1'b1;
        end
      end
    end
  end

  assign sts_o.row_done   = last_row;
  assign sts_o.site_done  = rd_v_q && (rd_q == HapBits'(MaxHaps - 1));
  assign sts_o.scan_done  = (row_q == (HapBits+1)'(MaxHaps - 1));
  assign sts_o.found      = found_q;
  assign sts_o.picks_done = (picked_q + 1'b1 >= 7'(want_q));
  assign sts_o.emit_done  = (row_q == (HapBits+1)'(MaxHaps - 1));
  assign sts_o.query_ok   = (NumBits'(query_q) < n_q) && (want_q != '0);
endmodule

// File: sv/hnn_checker.sv
// port level checker for the nearest neighbor selector
module hnn_sva (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               result_valid_o,
  input hnn_pkg::out_beat_t result_o
);
  import hnn_pkg::*;
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o)) else $error("result while idle");
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("no busy after accept");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !result_valid_o)
    else $error("beat right after last");
endmodule

bind hamming_nearest_neighbor_select hnn_sva u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .result_valid_o, .result_o
);
